/* rtl/psdd_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// psdd_pkg: shared types and constants for the pcm sample deinterleave decoder
// Holds sample format codes, register indexes and the queue entry type.
// ---------------------------------------------------------------------------
package psdd_pkg;

   // largest channel count the design supports
   localparam int MAX_CHANNELS = 8;

   // configuration port geometry
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 4;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_SAMPLE_FORMAT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHANNEL_COUNT = 2'd1;

   // sample format codes (also the index of the sample's last byte)
   localparam logic [1:0] FMT_U8  = 2'd0;
   localparam logic [1:0] FMT_S16 = 2'd1;
   localparam logic [1:0] FMT_S24 = 2'd2;
   localparam logic [1:0] FMT_F32 = 2'd3;

   // float32 field constants
   localparam logic [7:0] EXP_SPECIAL = 8'hFF;
   localparam logic [7:0] EXP_BIAS    = 8'd127;

   // Q1.23 saturation limits
   localparam logic [23:0] Q23_MAX = 24'h7FFFFF;
   localparam logic [23:0] Q23_MIN = 24'h800000;

   // one assembled sample handed from front to back
   typedef struct packed {
      logic [31:0] raw;
      logic [1:0]  fmt;
      logic [2:0]  chan;
      logic        last;
   } psdd_item_type;

   // queue status seen by the front and back
   typedef struct packed {
      logic full;
      logic empty;
   } psdd_qstat_type;

endpackage

/* rtl/psdd_front.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// psdd_front: byte gatherer and channel tracker
// Holds the configuration registers, merges little-endian bytes and pushes a
// completed sample with its channel tag into the queue.
// ---------------------------------------------------------------------------
module psdd_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic [psdd_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [psdd_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [7:0]                         req_data_byte,
   input  psdd_pkg::psdd_qstat_type           qstat,
   output logic                               push,
   output psdd_pkg::psdd_item_type            push_item
);

   logic [1:0]  sample_format_ff, sample_format_in;
   logic [3:0]  channel_count_ff, channel_count_in;
   logic [1:0]  byte_pos_ff, byte_pos_in;
   logic [2:0]  chan_pos_ff, chan_pos_in;
   logic [23:0] gathered_ff, gathered_in;

   logic        accept;
   logic        cfg_hit;
   logic [3:0]  chans;
   logic [2:0]  chan;
   logic        is_last;
   logic [31:0] full_word;

   // stall only when the queue cannot take another sample
   assign req_stall = qstat.full;
   assign accept    = req_valid && !req_stall;
   assign cfg_hit   = csr_wr_en && (csr_index == psdd_pkg::CSR_SAMPLE_FORMAT ||
                                    csr_index == psdd_pkg::CSR_CHANNEL_COUNT);

   // active channel count: zero means one, capped at the supported maximum
   always_comb begin
      chans = channel_count_ff;
      if (channel_count_ff == 4'd0) begin
         chans = 4'd1;
      end
      if (int'(chans) > psdd_pkg::MAX_CHANNELS) begin
         chans = 4'(psdd_pkg::MAX_CHANNELS);
      end
      if (chans > 4'd8) begin
         chans = 4'd8;
      end
   end

   // channel tag of the sample being finished
   always_comb begin
      chan = chan_pos_ff;
      if ({1'b0, chan_pos_ff} >= chans) begin
         chan = 3'(chans - 4'd1);
      end
      is_last = ({1'b0, chan} + 4'd1) >= chans;
   end

   // merge the incoming byte at its lane
   always_comb begin
      full_word = {8'd0, gathered_ff} | ({24'd0, req_data_byte} << {byte_pos_ff, 3'b000});
   end

   assign push              = accept && (byte_pos_ff == sample_format_ff);
   assign push_item.raw     = full_word;
   assign push_item.fmt     = sample_format_ff;
   assign push_item.chan    = chan;
   assign push_item.last    = is_last;

   // next state of registers and position counters
   always_comb begin
      sample_format_in = sample_format_ff;
      channel_count_in = channel_count_ff;
      byte_pos_in      = byte_pos_ff;
      chan_pos_in      = chan_pos_ff;
      gathered_in      = gathered_ff;
      if (cfg_hit) begin
         if (csr_index == psdd_pkg::CSR_SAMPLE_FORMAT) begin
            sample_format_in = csr_wdata[1:0];
         end else begin
            channel_count_in = csr_wdata[3:0];
         end
         byte_pos_in = 2'd0;
         chan_pos_in = 3'd0;
         gathered_in = 24'd0;
      end else if (accept) begin
         if (push) begin
            byte_pos_in = 2'd0;
            gathered_in = 24'd0;
            chan_pos_in = is_last ? 3'd0 : 3'(chan + 3'd1);
         end else begin
            byte_pos_in = 2'(byte_pos_ff + 2'd1);
            gathered_in = full_word[23:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_format_ff <= psdd_pkg::FMT_S16;
         channel_count_ff <= 4'd1;
         byte_pos_ff      <= 2'd0;
         chan_pos_ff      <= 3'd0;
         gathered_ff      <= 24'd0;
      end else begin
         sample_format_ff <= sample_format_in;
         channel_count_ff <= channel_count_in;
         byte_pos_ff      <= byte_pos_in;
         chan_pos_ff      <= chan_pos_in;
         gathered_ff      <= gathered_in;
      end
   end

endmodule

/* rtl/psdd_fifo.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// psdd_fifo: two-entry queue between front and back
// Decouples byte gathering from sample conversion so each can stall alone.
// ---------------------------------------------------------------------------
module psdd_fifo (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  psdd_pkg::psdd_item_type   push_item,
   input  logic                      pop,
   output psdd_pkg::psdd_item_type   pop_item,
   output psdd_pkg::psdd_qstat_type  qstat
);

   psdd_pkg::psdd_item_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign qstat.full  = (count_ff == 2'd2);
   assign qstat.empty = (count_ff == 2'd0);
   assign pop_item    = entry_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = 2'(count_ff + 2'd1);
      end else if (pop && !push) begin
         count_in = 2'(count_ff - 2'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

/* rtl/psdd_back.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// psdd_back: sample converter and output register
// Scales integer formats to Q1.23, converts float32 with truncation and
// saturation, and holds the result beat until the consumer takes it.
// ---------------------------------------------------------------------------
module psdd_back (
   input  logic                      clock,
   input  logic                      reset,
   input  psdd_pkg::psdd_qstat_type  qstat,
   input  psdd_pkg::psdd_item_type   pop_item,
   output logic                      pop,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [23:0]        rsp_sample_value,
   output logic [2:0]                rsp_channel_number,
   output logic                      rsp_frame_last,
   output logic                      rsp_clipped
);

   logic        rsp_valid_ff, rsp_valid_in;
   logic [23:0] value_ff;
   logic [2:0]  chan_ff;
   logic        last_ff;
   logic        clip_ff;

   logic        advance;
   logic [23:0] value;
   logic        clip;
   logic        f_neg;
   logic [7:0]  f_exp;
   logic [22:0] f_man;
   logic [7:0]  f_shift;
   logic [23:0] f_mag;

   // output register frees when empty or when its beat is taken
   assign advance = !rsp_valid_ff || !rsp_stall;
   assign pop     = advance && !qstat.empty;

   // float fields
   assign f_neg   = pop_item.raw[31];
   assign f_exp   = pop_item.raw[30:23];
   assign f_man   = pop_item.raw[22:0];
   assign f_shift = 8'(psdd_pkg::EXP_BIAS - f_exp);

   // float magnitude below one: truncating right shift of the full mantissa
   always_comb begin
      if (f_shift >= 8'd24) begin
         f_mag = 24'd0;
      end else begin
         f_mag = {1'b1, f_man} >> f_shift[4:0];
      end
   end

   // format selection and float special cases
   always_comb begin
      value = 24'd0;
      clip  = 1'b0;
      case (pop_item.fmt)
         psdd_pkg::FMT_U8: begin
            value = {pop_item.raw[7] ^ 1'b1, pop_item.raw[6:0], 16'd0};
         end
         psdd_pkg::FMT_S16: begin
            value = {pop_item.raw[15:0], 8'd0};
         end
         psdd_pkg::FMT_S24: begin
            value = pop_item.raw[23:0];
         end
         psdd_pkg::FMT_F32: begin
            if (f_exp == psdd_pkg::EXP_SPECIAL && f_man != 23'd0) begin
               value = 24'd0;
            end else if (f_exp == 8'd0) begin
               value = 24'd0;
            end else if (f_exp >= psdd_pkg::EXP_BIAS) begin
               if (f_neg && f_exp == psdd_pkg::EXP_BIAS && f_man == 23'd0) begin
                  value = psdd_pkg::Q23_MIN;
               end else begin
                  clip  = 1'b1;
                  value = f_neg ? psdd_pkg::Q23_MIN : psdd_pkg::Q23_MAX;
               end
            end else begin
               value = f_neg ? 24'(24'd0 - f_mag) : f_mag;
            end
         end
         default: begin
            value = 24'd0;
         end
      endcase
   end

   // valid of the output beat
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (pop) begin
         rsp_valid_in = 1'b1;
      end else if (advance) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // output payload
   always_ff @(posedge clock) begin
      if (pop) begin
         value_ff <= value;
         chan_ff  <= pop_item.chan;
         last_ff  <= pop_item.last;
         clip_ff  <= clip;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_sample_value   = $signed(value_ff);
   assign rsp_channel_number = chan_ff;
   assign rsp_frame_last     = last_ff;
   assign rsp_clipped        = clip_ff;

endmodule

/* rtl/pcm_sample_deinterleave_decoder_top.sv */
`timescale 1ns / 1ps
// path: a sample enters the queue with its last byte, then the output register
// throughput: one byte per cycle unless the queue is full; the front gathers,
// a two-entry queue and the output register let the converter run at one
// sample per cycle unless stalled; reset: synchronous, clears counters, queue
// and output valid; format resets to signed 16-bit and channel count to one
// ---------------------------------------------------------------------------
// pcm_sample_deinterleave_decoder_top: WAV PCM byte stream to Q1.23 samples
// Front gathers bytes and tags channels, back converts and presents results.
// ---------------------------------------------------------------------------
module pcm_sample_deinterleave_decoder_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic [psdd_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [psdd_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [7:0]                         req_data_byte,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [23:0]                 rsp_sample_value,
   output logic [2:0]                         rsp_channel_number,
   output logic                               rsp_frame_last,
   output logic                               rsp_clipped
);

   psdd_pkg::psdd_qstat_type qstat;
   psdd_pkg::psdd_item_type  push_item;
   psdd_pkg::psdd_item_type  pop_item;
   logic                     push;
   logic                     pop;

   // byte gatherer
   psdd_front u_front (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_byte (req_data_byte),
      .qstat         (qstat),
      .push          (push),
      .push_item     (push_item)
   );

   // sample queue
   psdd_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .pop_item  (pop_item),
      .qstat     (qstat)
   );

   // converter and output register
   psdd_back u_back (
      .clock              (clock),
      .reset              (reset),
      .qstat              (qstat),
      .pop_item           (pop_item),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_sample_value   (rsp_sample_value),
      .rsp_channel_number (rsp_channel_number),
      .rsp_frame_last     (rsp_frame_last),
      .rsp_clipped        (rsp_clipped)
   );

endmodule

/* verif/tb_pcm_sample_deinterleave_decoder_top.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_pcm_sample_deinterleave_decoder_top: self-checking bench for the decoder
// Streams WAV bytes under every format and random channel counts, tracks the
// byte and channel position in a scoreboard that computes each Q1.23 sample,
// and compares every result beat field by field under random gaps and stalls.
// ---------------------------------------------------------------------------
module tb_pcm_sample_deinterleave_decoder_top;

   // one decoded sample as the block should present it
   typedef struct {
      logic signed [23:0] value;
      logic [2:0]         chan;
      logic               last;
      logic               clip;
   } pcm_sample_type;

   // tracks stream position and holds the samples still owed by the block
   class sample_tracker;
      logic [1:0]     fmt;
      logic [3:0]     chan_count;
      logic [1:0]     byte_pos;
      logic [2:0]     chan_pos;
      logic [23:0]    gathered;
      pcm_sample_type owed_samples[$];
      int             errors;
      int             checked;
      int             saturated;

      function new();
         fmt        = psdd_pkg::FMT_S16;
         chan_count = 4'd1;
         clear_position();
         errors     = 0;
         checked    = 0;
         saturated  = 0;
      endfunction

      function void clear_position();
         byte_pos = '0;
         chan_pos = '0;
         gathered = '0;
      endfunction

      // any valid register write restarts decoding at a frame boundary
      function void write_reg(logic [psdd_pkg::CSR_INDEX_W-1:0] idx,
                              logic [psdd_pkg::CSR_DATA_W-1:0] data);
         if (idx == psdd_pkg::CSR_SAMPLE_FORMAT) begin
            fmt = data[1:0];
            clear_position();
         end else if (idx == psdd_pkg::CSR_CHANNEL_COUNT) begin
            chan_count = data;
            clear_position();
         end
      endfunction

      // float32 to Q1.23, truncating toward zero and saturating at +-1
      function void float_to_q23(input logic [31:0] bits, output logic [23:0] q,
                                 output logic clip);
         logic [7:0]  expo;
         logic [22:0] man;
         logic [31:0] mag;
         int          shift;
         expo = bits[30:23];
         man  = bits[22:0];
         clip = 1'b0;
         if (expo == psdd_pkg::EXP_SPECIAL && man != '0) begin
            q = '0;
         end else if (expo == '0) begin
            q = '0;
         end else if (expo >= psdd_pkg::EXP_BIAS) begin
            if (bits[31] && expo == psdd_pkg::EXP_BIAS && man == '0) begin
               q = psdd_pkg::Q23_MIN;
            end else begin
               clip = 1'b1;
               q    = bits[31] ? psdd_pkg::Q23_MIN : psdd_pkg::Q23_MAX;
            end
         end else begin
            shift = int'(psdd_pkg::EXP_BIAS) - int'(expo);
            mag   = (shift >= 32) ? 32'd0 : ({8'd0, 1'b1, man} >> shift);
            if (bits[31]) mag = -mag;
            q = mag[23:0];
         end
      endfunction

      // gather one accepted byte, owe a sample on the last byte
      function void note_byte(logic [7:0] b);
         logic [31:0]    full;
         logic [23:0]    q;
         logic           clip;
         logic [3:0]     chans;
         logic [2:0]     chan;
         pcm_sample_type s;
         if (byte_pos < fmt) begin
            gathered = gathered | (24'(b) << (8 * byte_pos));
            byte_pos = byte_pos + 2'd1;
            return;
         end
         full = {8'd0, gathered} | (32'(b) << (8 * byte_pos));
         clip = 1'b0;
         case (fmt)
            psdd_pkg::FMT_U8:  q = {full[7:0] ^ 8'h80, 16'h0000};
            psdd_pkg::FMT_S16: q = {full[15:0], 8'h00};
            psdd_pkg::FMT_S24: q = full[23:0];
            default:           float_to_q23(full, q, clip);
         endcase
         // zero channels counts as one, too many saturates
         chans = (chan_count == 0) ? 4'd1
               : (chan_count > psdd_pkg::MAX_CHANNELS) ? 4'(psdd_pkg::MAX_CHANNELS)
               : chan_count;
         chan = chan_pos;
         if ({1'b0, chan} >= chans) chan = 3'(chans - 4'd1);
         s.value = q;
         s.chan  = chan;
         s.last  = (chan + 1 >= chans);
         s.clip  = clip;
         owed_samples.push_back(s);
         chan_pos = s.last ? 3'd0 : chan + 3'd1;
         byte_pos = '0;
         gathered = '0;
      endfunction

      // compare one accepted result beat with the oldest owed sample
      function void check_sample(logic signed [23:0] value, logic [2:0] chan,
                                 logic last, logic clip);
         pcm_sample_type s;
         if (owed_samples.size() == 0) begin
            errors++;
            $display("%0t: unexpected sample beat value %h chan %0d", $time, value, chan);
            return;
         end
         s = owed_samples.pop_front();
         checked++;
         if (s.clip) saturated++;
         if (value !== s.value) begin
            errors++;
            $display("%0t: sample_value expected %h actual %h", $time, s.value, value);
         end
         if (chan !== s.chan) begin
            errors++;
            $display("%0t: channel_number expected %0d actual %0d", $time, s.chan, chan);
         end
         if (last !== s.last) begin
            errors++;
            $display("%0t: frame_last expected %b actual %b", $time, s.last, last);
         end
         if (clip !== s.clip) begin
            errors++;
            $display("%0t: clipped expected %b actual %b", $time, s.clip, clip);
         end
      endfunction
   endclass

   localparam int SETTLE_CYCLES = 8;

   logic                             clock;
   logic                             reset;
   logic                             csr_wr_en;
   logic [psdd_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [psdd_pkg::CSR_DATA_W-1:0]  csr_wdata;
   logic                             req_valid;
   logic                             req_stall;
   logic [7:0]                       req_data_byte;
   logic                             rsp_valid;
   logic                             rsp_stall;
   logic signed [23:0]               rsp_sample_value;
   logic [2:0]                       rsp_channel_number;
   logic                             rsp_frame_last;
   logic                             rsp_clipped;

   sample_tracker tracker;
   bit            req_no_gaps;
   bit            rsp_no_stalls;
   int            stall_hold;
   int            bytes_sent;
   int            csr_writes;

   pcm_sample_deinterleave_decoder_top dut (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_byte      (req_data_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_sample_value   (rsp_sample_value),
      .rsp_channel_number (rsp_channel_number),
      .rsp_frame_last     (rsp_frame_last),
      .rsp_clipped        (rsp_clipped)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // mostly short pauses, now and then a long one
   function automatic int pause_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 8);
      return $urandom_range(12, 40);
   endfunction

   // byte values biased toward the integer extremes
   function automatic logic [7:0] rand_byte();
      if ($urandom_range(0, 7) == 0) begin
         case ($urandom_range(0, 3))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'h7F;
            default: return 8'h80;
         endcase
      end
      return 8'($urandom());
   endfunction

   // float words spread over every exponent region that decodes differently
   function automatic logic [31:0] rand_float();
      logic [7:0]  expo;
      logic [22:0] man;
      int          r;
      r   = $urandom_range(0, 99);
      man = 23'($urandom());
      if (r < 6) begin
         expo = psdd_pkg::EXP_SPECIAL;
         if (r < 2) man = '0;
      end else if (r < 12) begin
         expo = '0;
         if (r < 8) man = '0;
      end else if (r < 20) begin
         expo = 8'($urandom_range(1, 95));
      end else if (r < 30) begin
         expo = psdd_pkg::EXP_BIAS;
         if (r < 25) man = '0;
      end else if (r < 40) begin
         expo = 8'($urandom_range(int'(psdd_pkg::EXP_BIAS) + 1,
                                  int'(psdd_pkg::EXP_SPECIAL) - 1));
      end else begin
         expo = 8'($urandom_range(96, int'(psdd_pkg::EXP_BIAS) - 1));
      end
      return {1'($urandom()), expo, man};
   endfunction

   // result side back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (stall_hold > 0) begin
         stall_hold = stall_hold - 1;
      end else if (rsp_no_stalls) begin
         rsp_stall <= 1'b0;
      end else if ($urandom_range(0, 99) < 35) begin
         rsp_stall <= 1'b1;
         stall_hold = pause_length() - 1;
      end else begin
         rsp_stall <= 1'b0;
         stall_hold = $urandom_range(0, 5);
      end
   end

   // result beat monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         tracker.check_sample(rsp_sample_value, rsp_channel_number, rsp_frame_last,
                              rsp_clipped);
   end

   // send one byte beat, with a random gap ahead of it
   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = (req_no_gaps || $urandom_range(0, 99) < 60) ? 0 : pause_length();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= b;
      do @(posedge clock); while (req_stall);
      tracker.note_byte(b);
      bytes_sent++;
   endtask

   // one sample, little-endian, as many bytes as the format takes
   task automatic send_sample(input logic [31:0] word);
      for (int k = 0; k <= tracker.fmt; k++) send_byte(word[8*k +: 8]);
   endtask

   // wait for all owed samples, then let the block settle
   task automatic wait_idle();
      while (tracker.owed_samples.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [psdd_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [psdd_pkg::CSR_DATA_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      tracker.write_reg(idx, data);
      csr_wr_en <= 1'b0;
      csr_writes++;
      @(posedge clock);
   endtask

   // set format and channel count once the block is idle
   task automatic configure(input logic [1:0] fmt, input logic [3:0] count);
      logic [psdd_pkg::CSR_DATA_W-1:0] fmt_data;
      fmt_data = {2'($urandom()), fmt};
      req_valid <= 1'b0;
      wait_idle();
      // writes to unmapped indexes must change nothing
      if ($urandom_range(0, 3) == 0)
         write_csr(psdd_pkg::CSR_INDEX_W'($urandom_range(
                      int'(psdd_pkg::CSR_CHANNEL_COUNT) + 1,
                      (1 << psdd_pkg::CSR_INDEX_W) - 1)),
                   psdd_pkg::CSR_DATA_W'($urandom()));
      if ($urandom_range(0, 1) == 1) begin
         write_csr(psdd_pkg::CSR_SAMPLE_FORMAT, fmt_data);
         write_csr(psdd_pkg::CSR_CHANNEL_COUNT, count);
      end else begin
         write_csr(psdd_pkg::CSR_CHANNEL_COUNT, count);
         write_csr(psdd_pkg::CSR_SAMPLE_FORMAT, fmt_data);
      end
   endtask

   // limit
   initial begin
      #20ms;
      $display("** pcm_sample_deinterleave_decoder_top: FAILED **");
      $finish;
   end

   // stimulus
   initial begin
      logic [1:0] fixed_fmt[4];
      logic [3:0] fixed_count[4];
      logic [1:0] fmt;
      int         phase;
      fixed_fmt     = '{psdd_pkg::FMT_U8, psdd_pkg::FMT_S24, psdd_pkg::FMT_F32,
                        psdd_pkg::FMT_S16};
      fixed_count   = '{4'd0, 4'd15, 4'd8, 4'd1};
      reset         = 1'b1;
      csr_wr_en     = 1'b0;
      csr_index     = '0;
      csr_wdata     = '0;
      req_valid     = 1'b0;
      req_data_byte = '0;
      rsp_stall     = 1'b0;
      req_no_gaps   = 1'b0;
      rsp_no_stalls = 1'b0;
      stall_hold    = 0;
      bytes_sent    = 0;
      csr_writes    = 0;
      tracker       = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset format: most negative 16-bit sample
      send_sample(32'h0000_8000);

      // float special cases over three channels
      configure(psdd_pkg::FMT_F32, 4'd3);
      send_sample(32'h7FC0_0001);   // nan
      send_sample(32'hFF80_0000);   // negative infinity
      send_sample(32'hBF80_0000);   // exactly -1.0
      send_sample(32'h3F80_0000);   // +1.0 saturates
      send_sample(32'hBF00_0000);   // -0.5
      send_sample(32'h0000_0001);   // subnormal

      // random phases, extremes of the settings first
      phase = 0;
      while (bytes_sent < 1650) begin
         fmt = (phase < 4) ? fixed_fmt[phase] : 2'($urandom());
         configure(fmt, (phase < 4) ? fixed_count[phase] : 4'($urandom()));
         req_no_gaps   = ($urandom_range(0, 4) == 0);
         rsp_no_stalls = ($urandom_range(0, 4) == 0);
         repeat ($urandom_range(4, 50))
            send_sample((fmt == psdd_pkg::FMT_F32) ? rand_float()
                        : {rand_byte(), rand_byte(), rand_byte(), rand_byte()});
         // sometimes leave a sample unfinished before the next write
         if (fmt != psdd_pkg::FMT_U8 && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, fmt)) send_byte(rand_byte());
         phase++;
      end

      req_valid <= 1'b0;
      wait_idle();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("covered %0d byte beats in %0d phases, %0d register writes",
               bytes_sent, phase + 2, csr_writes);
      $display("checked %0d samples, %0d of them saturated floats",
               tracker.checked, tracker.saturated);
      if (tracker.errors == 0 && tracker.owed_samples.size() == 0)
         $display("** pcm_sample_deinterleave_decoder_top: PASSED **");
      else
         $display("** pcm_sample_deinterleave_decoder_top: FAILED **");
      $finish;
   end

endmodule
